// ===== hw/rtl/windowed_rms_power_accumulator_macros.svh =====
`ifndef WINDOWED_RMS_POWER_ACCUMULATOR_MACROS_SVH
`define WINDOWED_RMS_POWER_ACCUMULATOR_MACROS_SVH

// same-cycle check
`define WRPA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle check
`define WRPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/wrpa_pkg.sv =====
package wrpa_pkg;

    localparam int PERIOD_W   = 11;
    localparam int SAMPLE_W   = 13;
    localparam int ENTRY_W    = 16;
    localparam int SUM_W      = 32;

    localparam int POWER_SHIFT = 12;
    localparam int VOLT_SHIFT  = 12;
    localparam int LOAD_SHIFT  = 6;
    localparam int IND_SHIFT   = 11;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 11'd1024;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [ENTRY_W-1:0]         entry_t;
    typedef logic [SUM_W-1:0]           sum_t;

    typedef struct packed {
        entry_t power;
        entry_t out_voltage;
        entry_t in_voltage;
        entry_t load;
        entry_t inductor;
    } ring_entry_t;

    function automatic sum_t sext_entry(input entry_t e);
        return {{(SUM_W-ENTRY_W){e[ENTRY_W-1]}}, e};
    endfunction

endpackage

// ===== hw/rtl/wrpa_ring_ram.sv =====
module wrpa_ring_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 80
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/wrpa_entry_calc.sv =====
module wrpa_entry_calc
    import wrpa_pkg::*;
(
    input  sample_t     out_voltage,
    input  sample_t     in_voltage,
    input  sample_t     load_current,
    input  sample_t     inductor_current,
    output ring_entry_t entry
);

    localparam int PROD_W = 2 * SAMPLE_W;

    function automatic logic [SAMPLE_W-1:0] mag(input sample_t x);
        return x[SAMPLE_W-1] ? SAMPLE_W'(-x) : SAMPLE_W'(x);
    endfunction

    logic signed [PROD_W-1:0] power_prod;
    logic signed [PROD_W-1:0] power_shifted;
    logic [SAMPLE_W-1:0]      ov_mag;
    logic [SAMPLE_W-1:0]      iv_mag;
    logic [SAMPLE_W-1:0]      load_mag;
    logic [SAMPLE_W-1:0]      ind_mag;
    logic [PROD_W-1:0]        ov_sq;
    logic [PROD_W-1:0]        iv_sq;
    logic [PROD_W-1:0]        load_sq;
    logic [PROD_W-1:0]        ind_sq;

    always_comb
    begin
        power_prod    = PROD_W'(out_voltage) * PROD_W'(inductor_current);
        // arithmetic shift gives the floor for negative products
        power_shifted = power_prod >>> POWER_SHIFT;

        ov_mag   = mag(out_voltage);
        iv_mag   = mag(in_voltage);
        load_mag = mag(load_current);
        ind_mag  = mag(inductor_current);

        ov_sq   = PROD_W'(ov_mag) * PROD_W'(ov_mag);
        iv_sq   = PROD_W'(iv_mag) * PROD_W'(iv_mag);
        load_sq = PROD_W'(load_mag) * PROD_W'(load_mag);
        ind_sq  = PROD_W'(ind_mag) * PROD_W'(ind_mag);

        entry.power       = power_shifted[ENTRY_W-1:0];
        entry.out_voltage = ENTRY_W'(ov_sq >> VOLT_SHIFT);
        entry.in_voltage  = ENTRY_W'(iv_sq >> VOLT_SHIFT);
        // load term may exceed 16 bits and wraps
        entry.load        = ENTRY_W'(load_sq >> LOAD_SHIFT);
        entry.inductor    = ENTRY_W'(ind_sq >> IND_SHIFT);
    end

endmodule

// ===== hw/rtl/windowed_rms_power_accumulator.sv =====
// Sliding-window power and sum-of-squares accumulator. Takes one set of four
// samples per clock unless out_stall holds the pipeline, and returns one set
// of five 32-bit window sums per set through the stage 1, stage 2 and sum
// registers; the rate is set by the ring RAM, read one stage ahead of the
// accumulator stage and written in it, with a bypass when both touch the same
// slot. Window entries live in one WINDOW_DEPTH x 80-bit RAM. After reset the
// RAM is not swept: a fill count marks the slots written so far and slots
// beyond it read as zero, so requests are taken right away. The user writes
// period_points through the cfg port only while no request is in flight (not
// enforced); values above WINDOW_DEPTH act as WINDOW_DEPTH, zero acts as one.
`include "windowed_rms_power_accumulator_macros.svh"

module windowed_rms_power_accumulator
    import wrpa_pkg::*;
#(
    parameter int WINDOW_DEPTH = 1024
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [PERIOD_W-1:0] cfg_data,

    input  logic                in_valid,
    output logic                in_stall,
    input  sample_t             out_voltage,
    input  sample_t             in_voltage,
    input  sample_t             load_current,
    input  sample_t             inductor_current,

    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [SUM_W-1:0] power_sum,
    output logic signed [SUM_W-1:0] out_voltage_square_sum,
    output logic signed [SUM_W-1:0] in_voltage_square_sum,
    output logic signed [SUM_W-1:0] load_square_sum,
    output logic signed [SUM_W-1:0] inductor_square_sum,
    output logic                window_wrapped
);

    localparam int IDX_W  = $clog2(WINDOW_DEPTH);
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int CMP_W  = (IDX_W + 1 > PERIOD_W) ? IDX_W + 1 : PERIOD_W;
    localparam logic [CMP_W-1:0]  DEPTH_CMP  = CMP_W'(WINDOW_DEPTH);
    localparam logic [FILL_W-1:0] DEPTH_FILL = FILL_W'(WINDOW_DEPTH);

    // handshake / pipeline control
    logic en0;
    logic en1;
    logic en2;
    logic in_accept;
    logic rd_en;
    logic wr_en;
    logic fwd;

    // config and window position
    logic [PERIOD_W-1:0] period_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [CMP_W-1:0]    len;
    logic [CMP_W-1:0]    idx_inc;
    logic                wrap_now;

    // stage 1
    logic             s1_valid_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             s1_wrap_reg;
    sample_t          s1_ov_reg;
    sample_t          s1_iv_reg;
    sample_t          s1_load_reg;
    sample_t          s1_ind_reg;
    ring_entry_t      s1_entry;

    // stage 2
    logic             s2_valid_reg;
    logic [IDX_W-1:0] s2_idx_reg;
    logic             s2_wrap_reg;
    ring_entry_t      s2_entry_reg;
    logic             s2_fwd_reg;
    logic             s2_old_ok_reg;
    ring_entry_t      s2_fwd_entry_reg;
    logic [$bits(ring_entry_t)-1:0] rd_data;
    ring_entry_t      old_entry;

    logic [FILL_W-1:0] fill_reg;

    // sums and output
    sum_t power_acc_reg;
    sum_t ov_acc_reg;
    sum_t iv_acc_reg;
    sum_t load_acc_reg;
    sum_t ind_acc_reg;
    sum_t ov_hold_reg;
    sum_t iv_hold_reg;
    sum_t power_acc_next;
    sum_t ov_acc_next;
    sum_t iv_acc_next;
    sum_t load_acc_next;
    sum_t ind_acc_next;
    sum_t ov_hold_next;
    sum_t iv_hold_next;
    logic out_valid_reg;
    logic wrapped_reg;

    assign en2       = !out_valid_reg || !out_stall;
    assign en1       = !s2_valid_reg || en2;
    assign en0       = !s1_valid_reg || en1;
    assign in_stall  = !en0;
    assign in_accept = in_valid && en0;
    assign rd_en     = s1_valid_reg && en1;
    assign wr_en     = s2_valid_reg && en2;
    assign fwd       = rd_en && wr_en && (s1_idx_reg == s2_idx_reg);
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_valid)
        begin
            period_reg <= cfg_data;
        end
    end

    always_comb
    begin
        len      = (CMP_W'(period_reg) > DEPTH_CMP) ? DEPTH_CMP : CMP_W'(period_reg);
        idx_inc  = CMP_W'(idx_reg) + CMP_W'(1);
        wrap_now = (idx_inc >= len);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                idx_reg <= wrap_now ? '0 : idx_inc[IDX_W-1:0];
            end
            if (en0)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en1)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en2)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_idx_reg  <= idx_reg;
            s1_wrap_reg <= wrap_now;
            s1_ov_reg   <= out_voltage;
            s1_iv_reg   <= in_voltage;
            s1_load_reg <= load_current;
            s1_ind_reg  <= inductor_current;
        end
    end

    wrpa_entry_calc u_calc (
        .out_voltage      (s1_ov_reg),
        .in_voltage       (s1_iv_reg),
        .load_current     (s1_load_reg),
        .inductor_current (s1_ind_reg),
        .entry            (s1_entry)
    );

    wrpa_ring_ram #(
        .DEPTH (WINDOW_DEPTH),
        .WIDTH ($bits(ring_entry_t))
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s2_idx_reg),
        .wr_data (s2_entry_reg),
        .rd_en   (rd_en),
        .rd_addr (s1_idx_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s2_idx_reg       <= s1_idx_reg;
            s2_wrap_reg      <= s1_wrap_reg;
            s2_entry_reg     <= s1_entry;
            s2_fwd_reg       <= fwd;
            s2_fwd_entry_reg <= s2_entry_reg;
            s2_old_ok_reg    <= (FILL_W'(s1_idx_reg) < fill_reg);
        end
    end

    // slots at or past the fill count were never written and read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (wr_en && (FILL_W'(s2_idx_reg) >= fill_reg))
        begin
            fill_reg <= FILL_W'(s2_idx_reg) + FILL_W'(1);
        end
    end

    always_comb
    begin
        if (s2_fwd_reg)
        begin
            old_entry = s2_fwd_entry_reg;
        end
        else if (s2_old_ok_reg)
        begin
            old_entry = rd_data;
        end
        else
        begin
            old_entry = '0;
        end

        power_acc_next = power_acc_reg - sext_entry(old_entry.power)
                         + sext_entry(s2_entry_reg.power);
        load_acc_next  = load_acc_reg - sext_entry(old_entry.load)
                         + sext_entry(s2_entry_reg.load);
        ind_acc_next   = ind_acc_reg - sext_entry(old_entry.inductor)
                         + sext_entry(s2_entry_reg.inductor);
        ov_acc_next    = ov_acc_reg - sext_entry(old_entry.out_voltage)
                         + sext_entry(s2_entry_reg.out_voltage);
        iv_acc_next    = iv_acc_reg - sext_entry(old_entry.in_voltage)
                         + sext_entry(s2_entry_reg.in_voltage);
        ov_hold_next   = ov_hold_reg + sext_entry(s2_entry_reg.out_voltage);
        iv_hold_next   = iv_hold_reg + sext_entry(s2_entry_reg.in_voltage);

        // end of window: period holds replace the voltage sums
        if (s2_wrap_reg)
        begin
            ov_acc_next  = ov_hold_next;
            iv_acc_next  = iv_hold_next;
            ov_hold_next = '0;
            iv_hold_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_acc_reg <= '0;
            ov_acc_reg    <= '0;
            iv_acc_reg    <= '0;
            load_acc_reg  <= '0;
            ind_acc_reg   <= '0;
            ov_hold_reg   <= '0;
            iv_hold_reg   <= '0;
            wrapped_reg   <= 1'b0;
        end
        else if (wr_en)
        begin
            power_acc_reg <= power_acc_next;
            ov_acc_reg    <= ov_acc_next;
            iv_acc_reg    <= iv_acc_next;
            load_acc_reg  <= load_acc_next;
            ind_acc_reg   <= ind_acc_next;
            ov_hold_reg   <= ov_hold_next;
            iv_hold_reg   <= iv_hold_next;
            wrapped_reg   <= s2_wrap_reg;
        end
    end

    assign out_valid              = out_valid_reg;
    assign power_sum              = power_acc_reg;
    assign out_voltage_square_sum = ov_acc_reg;
    assign in_voltage_square_sum  = iv_acc_reg;
    assign load_square_sum        = load_acc_reg;
    assign inductor_square_sum    = ind_acc_reg;
    assign window_wrapped         = wrapped_reg;

    `WRPA_ASSERT_SAME(a_fill_bound, 1'b1, fill_reg <= DEPTH_FILL, "fill count past ring depth")
    `WRPA_ASSERT_NEXT(a_wrap_index, in_accept && wrap_now, idx_reg == '0, "index not cleared on wrap")
    `WRPA_ASSERT_NEXT(a_hold_clear, wr_en && s2_wrap_reg, ov_hold_reg == '0 && iv_hold_reg == '0, "period hold not cleared")

endmodule
